[sv/pkrl_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and register codes of the per-key rate limiter
// no dependencies
package pkrl_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int HALF_W = 64;
  localparam int KEY_W  = 2 * HALF_W;
  localparam int TIME_W = 32;
  localparam int WIN_W  = 16;
  localparam int HITS_W = 8;
  localparam int HC_W   = HITS_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0]  WIN_RESET      = WIN_W'(60);
  localparam logic [HITS_W-1:0] MAX_HITS_RESET = HITS_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW   = 2'd0,
    CFG_MAX_HITS = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [HC_W-1:0]   hits;
  } st_word_t;

  localparam int ST_W = $bits(st_word_t);

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             key_we;
    logic             st_we;
    logic [IDX_W-1:0] wr_addr;
  } mem_req_t;

endpackage

[sv/pkrl_if.sv]
`timescale 1ns / 1ps
// request and response channels with valid/ready handshake
// depends on pkrl_pkg
interface pkrl_req_if;
  import pkrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] addr_high;
  logic [HALF_W-1:0] addr_low;
  logic [TIME_W-1:0] now_seconds;
  modport source (output valid, addr_high, addr_low, now_seconds, input ready);
  modport sink (input valid, addr_high, addr_low, now_seconds, output ready);
endinterface

interface pkrl_rsp_if;
  logic valid;
  logic ready;
  logic allowed;
  logic table_flushed;
  modport source (output valid, allowed, table_flushed, input ready);
  modport sink (input valid, allowed, table_flushed, output ready);
endinterface

[sv/pkrl_ram.sv]
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram, registered read data
// no dependencies
module pkrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pkrl_ctrl.sv]
`timescale 1ns / 1ps
// search sequencer: scans the key memory and appends missing keys, updates the window memory,
// holds config registers and the response register; depends on pkrl_pkg, pkrl_if
module pkrl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pkrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pkrl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pkrl_req_if.sink                      req,
  pkrl_rsp_if.source                    rsp,
  output pkrl_pkg::mem_req_t            mem_o,
  output logic [pkrl_pkg::KEY_W-1:0]    key_wdata_o,
  output pkrl_pkg::st_word_t            st_wdata_o,
  input  logic [pkrl_pkg::KEY_W-1:0]    key_rdata_i,
  input  pkrl_pkg::st_word_t            st_rdata_i
);
  import pkrl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [HALF_W-1:0] hi_q, lo_q;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  used_q, issue_q, fill_q;
  logic              pvalid_q;
  logic [IDX_W-1:0]  pidx_q;
  logic [WIN_W-1:0]  window_q;
  logic [HITS_W-1:0] max_hits_q;
  logic              res_allowed_q, res_flushed_q;
  logic              out_valid_q, out_allowed_q, out_flushed_q;

  logic              accept;
  logic              out_load;
  logic              hit, more, miss, table_full;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic [HC_W-1:0]   hits_inc;
  logic              hit_allowed;
  st_word_t          hit_word;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
  assign hit        = (state_q == S_SCAN) && pvalid_q && (key_rdata_i == {hi_q, lo_q});
  assign more       = (issue_q < used_q);
  assign miss       = (state_q == S_SCAN) && !hit && !more;
  assign table_full = (used_q == CNT_W'(TABLE_ENTRIES));

  assign age      = now_q - st_rdata_i.start;
  assign expired  = age > {{(TIME_W - WIN_W){1'b0}}, window_q};
  assign hits_inc = (st_rdata_i.hits <= {1'b0, max_hits_q}) ?
                    st_rdata_i.hits + 1'b1 : st_rdata_i.hits;
  assign hit_allowed = expired || (hits_inc <= {1'b0, max_hits_q});

  always_comb begin
    if (expired) begin
      hit_word.start = now_q;
      hit_word.hits  = HC_W'(1);
    end else begin
      hit_word.start = st_rdata_i.start;
      hit_word.hits  = hits_inc;
    end
  end

  always_comb begin
    mem_o         = '0;
    key_wdata_o   = {hi_q, lo_q};
    st_wdata_o    = hit_word;
    if (state_q == S_IDLE) begin
      mem_o.rd_en   = accept && (fill_q != '0);
      mem_o.rd_addr = '0;
    end else if (state_q == S_SCAN) begin
      mem_o.rd_en   = more && !hit;
      mem_o.rd_addr = issue_q[IDX_W-1:0];
      if (hit) begin
        mem_o.st_we   = 1'b1;
        mem_o.wr_addr = pidx_q;
      end else if (miss && !table_full) begin
        mem_o.key_we     = 1'b1;
        mem_o.st_we      = 1'b1;
        mem_o.wr_addr    = used_q[IDX_W-1:0];
        st_wdata_o.start = now_q;
        st_wdata_o.hits  = HC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      hi_q          <= '0;
      lo_q          <= '0;
      now_q         <= '0;
      fill_q        <= '0;
      pvalid_q      <= 1'b0;
      pidx_q        <= '0;
      issue_q       <= '0;
      used_q        <= '0;
      window_q      <= WIN_RESET;
      max_hits_q    <= MAX_HITS_RESET;
      out_valid_q   <= 1'b0;
      res_allowed_q <= 1'b0;
      res_flushed_q <= 1'b0;
      out_allowed_q <= 1'b0;
      out_flushed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW:   window_q   <= cfg_data_i[WIN_W-1:0];
          CFG_MAX_HITS: max_hits_q <= cfg_data_i[HITS_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q   <= 1'b1;
        out_allowed_q <= res_allowed_q;
        out_flushed_q <= res_flushed_q;
      end else if (rsp.valid && rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      pvalid_q <= mem_o.rd_en;
      pidx_q   <= mem_o.rd_addr;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            hi_q    <= req.addr_high;
            lo_q    <= req.addr_low;
            now_q   <= req.now_seconds;
            used_q  <= fill_q;
            issue_q <= (fill_q != '0) ? CNT_W'(1) : '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (more && !hit) begin
            issue_q <= issue_q + 1'b1;
          end
          if (hit) begin
            res_allowed_q <= hit_allowed;
            res_flushed_q <= 1'b0;
            state_q       <= S_DONE;
          end else if (miss) begin
            res_allowed_q <= 1'b1;
            res_flushed_q <= table_full;
            fill_q        <= table_full ? '0 : used_q + 1'b1;
            state_q       <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.allowed       = out_allowed_q;
  assign rsp.table_flushed = out_flushed_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |-> !(mem_o.st_we || mem_o.key_we))
    else $error("memory write outside scan");

  a_key_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.key_we |=> fill_q == CNT_W'($past(fill_q) + 1'b1))
    else $error("new entry without fill count step");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("response raised outside completion");

  a_single_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !rsp.ready) |=> state_q == S_DONE)
    else $error("response overwritten while stalled");

endmodule

[sv/per_key_fixed_window_rate_limiter_top.sv]
`timescale 1ns / 1ps
// channel     dir  handshake    payload
// req_i       in   valid/ready  addr_high[64] addr_low[64] now_seconds[32]
// rsp_o       out  valid/ready  allowed table_flushed
// cfg_*_i     in   write enable index[2] data[16]
//
// a request passes the accept state, the scan state, which checks the filled entries
// in turn up to the hit, and the completion state; the linear scan of the key ram reads
// one entry per cycle
// a new request is taken while the previous response still waits on rsp_o
// reset clears the fill count and restores the window and hit limit registers
// depends on pkrl_pkg, pkrl_if, pkrl_ram, pkrl_ctrl
module per_key_fixed_window_rate_limiter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pkrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pkrl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pkrl_req_if.sink                        req_i,
  pkrl_rsp_if.source                      rsp_o
);
  import pkrl_pkg::*;

  mem_req_t         mem_req;
  logic [KEY_W-1:0] key_wdata, key_rdata;
  st_word_t         st_wdata, st_rdata;
  logic [ST_W-1:0]  st_rdata_raw;

  pkrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_o       (mem_req),
    .key_wdata_o (key_wdata),
    .st_wdata_o  (st_wdata),
    .key_rdata_i (key_rdata),
    .st_rdata_i  (st_rdata)
  );

  pkrl_ram #(.Width(KEY_W), .Depth(TABLE_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.key_we),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (key_wdata),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (key_rdata)
  );

  pkrl_ram #(.Width(ST_W), .Depth(TABLE_ENTRIES)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.st_we),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (st_wdata),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (st_rdata_raw)
  );

  assign st_rdata = st_word_t'(st_rdata_raw);

endmodule

[dv/per_key_fixed_window_rate_limiter_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the per-key fixed-window rate limiter: directed table, then
// random phases with several window and hit limit settings, checked against a local predictor
// depends on pkrl_pkg, pkrl_if and per_key_fixed_window_rate_limiter_top
module per_key_fixed_window_rate_limiter_top_tb;
  import pkrl_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP       = 4;
  localparam int POOL_DEPTH    = 24;
  localparam int NUM_PHASES    = 6;
  localparam int NUM_DIRECTED  = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [HALF_W-1:0]    ONES        = '1;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [HALF_W-1:0]     hi;
    logic [HALF_W-1:0]     lo;
    logic [TIME_W-1:0]     now;
    logic                  typed;
    logic                  allowed;
    logic                  flushed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } step_t;

  typedef struct packed {
    logic allowed;
    logic flushed;
  } verdict_t;

  localparam step_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_REQ, 64'd0, 64'd0, 32'd0,          1'b1, 1'b1, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, ONES,  ONES,  32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd0, 32'd1,          1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd0, 32'd2,          1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd0, 32'd3,          1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd0, 32'd4,          1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd0, 32'd5,          1'b1, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    // age equal to the window, count stays saturated
    '{ROW_REQ, 64'd0, 64'd0, 32'd60,         1'b1, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd0, 32'd61,         1'b1, 1'b1, 1'b0, CFG_WINDOW,   16'h0000},
    // age across the time wrap
    '{ROW_REQ, ONES,  ONES,  32'd59,         1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, ONES,  ONES,  32'd60,         1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd1, 64'd0, 32'd100,        1'b1, 1'b1, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd1, 32'd100,        1'b1, 1'b1, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_CFG, 64'd0, 64'd0, 32'd0,          1'b0, 1'b0, 1'b0, CFG_SPARE_2,  16'hFFFF},
    '{ROW_CFG, 64'd0, 64'd0, 32'd0,          1'b0, 1'b0, 1'b0, CFG_SPARE_3,  16'hFFFF},
    '{ROW_CFG, 64'd0, 64'd0, 32'd0,          1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_CFG, 64'd0, 64'd0, 32'd0,          1'b0, 1'b0, 1'b0, CFG_MAX_HITS, 16'hFF00},
    // zero window and zero hit limit
    '{ROW_REQ, 64'd1, 64'd0, 32'd100,        1'b1, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd1, 64'd0, 32'd101,        1'b1, 1'b1, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd1, 32'd100,        1'b1, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_CFG, 64'd0, 64'd0, 32'd0,          1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'hFFFF},
    '{ROW_CFG, 64'd0, 64'd0, 32'd0,          1'b0, 1'b0, 1'b0, CFG_MAX_HITS, 16'h00FF},
    '{ROW_REQ, 64'd0, 64'd0, 32'd65596,      1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, 64'd0, 64'd0, 32'd65597,      1'b0, 1'b0, 1'b0, CFG_WINDOW,   16'h0000},
    '{ROW_REQ, ONES,  64'd0, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, CFG_WINDOW,   16'h0000}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pkrl_req_if req_if ();
  pkrl_rsp_if rsp_if ();

  per_key_fixed_window_rate_limiter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // local copy of the address table and limits
  logic [HALF_W-1:0] tbl_hi    [TABLE_ENTRIES];
  logic [HALF_W-1:0] tbl_lo    [TABLE_ENTRIES];
  logic [TIME_W-1:0] tbl_start [TABLE_ENTRIES];
  logic [HC_W-1:0]   tbl_hits  [TABLE_ENTRIES];
  int                tbl_fill;
  logic [WIN_W-1:0]  lim_window;
  logic [HITS_W-1:0] lim_hits;

  verdict_t    verdict_q [$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  logic        burst       = 1'b0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic verdict_t rate_decide(input logic [HALF_W-1:0] hi,
                                           input logic [HALF_W-1:0] lo,
                                           input logic [TIME_W-1:0] now);
    verdict_t          v;
    logic [TIME_W-1:0] age;
    logic [HC_W-1:0]   h;
    int                n;
    v.allowed = 1'b1;
    v.flushed = 1'b0;
    for (n = 0; n < tbl_fill; n++) begin
      if (tbl_hi[n] == hi && tbl_lo[n] == lo) begin
        age = now - tbl_start[n];
        if (age > TIME_W'(lim_window)) begin
          tbl_start[n] = now;
          tbl_hits[n]  = HC_W'(1);
        end else begin
          h = tbl_hits[n];
          if (h <= HC_W'(lim_hits)) h = h + 1'b1;
          tbl_hits[n] = h;
          v.allowed   = (h <= HC_W'(lim_hits));
        end
        return v;
      end
    end
    if (tbl_fill < TABLE_ENTRIES) begin
      tbl_hi[tbl_fill]    = hi;
      tbl_lo[tbl_fill]    = lo;
      tbl_start[tbl_fill] = now;
      tbl_hits[tbl_fill]  = HC_W'(1);
      tbl_fill++;
    end else begin
      tbl_fill  = 0;
      v.flushed = 1'b1;
    end
    return v;
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WINDOW) lim_window = data;
    else if (idx == CFG_MAX_HITS) lim_hits = data[HITS_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic send_req(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                          input logic [TIME_W-1:0] now, input logic typed,
                          input verdict_t want);
    int       gap;
    verdict_t v;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.addr_high   <= hi;
    req_if.addr_low    <= lo;
    req_if.now_seconds <= now;
    do @(posedge clk_i); while (!req_if.ready);
    v = rate_decide(hi, lo, now);
    verdict_q.push_back(typed ? want : v);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // response side back-pressure
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  always @(posedge clk_i) begin : rsp_check
    verdict_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected response transaction");
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (rsp_if.allowed !== want.allowed) begin
          $error("allowed: expected %0b, got %0b", want.allowed, rsp_if.allowed);
          err_count++;
        end
        if (rsp_if.table_flushed !== want.flushed) begin
          $error("table_flushed: expected %0b, got %0b", want.flushed, rsp_if.table_flushed);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int                n;
    int                phase;
    int                count;
    int                new_pct;
    int                hot_pct;
    int                drift_pct;
    int                r;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  src;
    logic [KEY_W-1:0]  hot_key;
    logic [KEY_W-1:0]  pool [$];
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] win32;
    logic [WIN_W-1:0]  set_win;
    logic [HITS_W-1:0] set_hits;
    verdict_t          want;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_WINDOW;
    cfg_data_i         <= '0;
    req_if.valid       <= 1'b0;
    req_if.addr_high   <= '0;
    req_if.addr_low    <= '0;
    req_if.now_seconds <= '0;
    tbl_fill   = 0;
    lim_window = WIN_RESET;
    lim_hits   = MAX_HITS_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < NUM_DIRECTED; n++) begin
      if (DIRECTED[n].kind == ROW_CFG) begin
        drain();
        cfg_write(DIRECTED[n].idx, DIRECTED[n].data);
      end else begin
        want = {DIRECTED[n].allowed, DIRECTED[n].flushed};
        send_req(DIRECTED[n].hi, DIRECTED[n].lo, DIRECTED[n].now, DIRECTED[n].typed, want);
      end
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          set_win = WIN_W'($urandom_range(1, 20));
          set_hits = HITS_W'($urandom_range(1, 8));
          new_pct = 25; hot_pct = 30; drift_pct = 50; count = 300;
        end
        1: begin
          set_win = '0; set_hits = '0;
          new_pct = 30; hot_pct = 20; drift_pct = 50; count = 250;
        end
        // long window, high limit, one address hammered to saturation
        2: begin
          set_win = '1; set_hits = '1;
          new_pct = 5; hot_pct = 85; drift_pct = 100; count = 400;
        end
        3: begin
          set_win = WIN_W'($urandom_range(1, 65535));
          set_hits = HITS_W'($urandom_range(1, 255));
          new_pct = 40; hot_pct = 20; drift_pct = 50; count = 300;
        end
        4: begin
          set_win = WIN_W'(1); set_hits = HITS_W'(1);
          new_pct = 40; hot_pct = 20; drift_pct = 50; count = 300;
        end
        default: begin
          set_win = WIN_W'($urandom_range(2, 200));
          set_hits = HITS_W'($urandom_range(1, 16));
          new_pct = 35; hot_pct = 25; drift_pct = 50; count = 250;
        end
      endcase
      cfg_write(CFG_WINDOW, set_win);
      cfg_write(CFG_MAX_HITS, {8'($urandom), set_hits});
      win32    = TIME_W'(set_win);
      cur_time = (phase % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom;
      hot_key  = {$urandom, $urandom, $urandom, $urandom};
      burst    = (phase == 4);

      for (n = 0; n < count; n++) begin
        if (n == count / 2) drain();

        r = $urandom_range(0, 99);
        if (r < new_pct || pool.size() == 0) begin
          src = (pool.size() != 0) ? pool[$urandom_range(0, pool.size() - 1)] : hot_key;
          case ($urandom_range(0, 3))
            0:       key = {$urandom, $urandom, $urandom, $urandom};
            1:       key = {$urandom, $urandom, src[HALF_W-1:0]};
            2:       key = {src[KEY_W-1:HALF_W], $urandom, $urandom};
            default: key = src ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
          endcase
          pool.push_back(key);
          if (pool.size() > POOL_DEPTH) void'(pool.pop_front());
        end else if (r < new_pct + hot_pct) begin
          key = hot_key;
        end else begin
          key = pool[$urandom_range(0, pool.size() - 1)];
        end

        if ($urandom_range(0, 99) < drift_pct) begin
          cur_time = cur_time + $urandom_range(0, 3);
        end else begin
          case ($urandom_range(0, 4))
            0:       cur_time = cur_time + $urandom_range(0, win32);
            1:       cur_time = cur_time + win32;
            2:       cur_time = cur_time + win32 + 1;
            3:       cur_time = cur_time + $urandom_range(0, 2 * win32 + 2);
            default: cur_time = $urandom;
          endcase
        end

        send_req(key[KEY_W-1:HALF_W], key[HALF_W-1:0], cur_time, 1'b0, '0);
      end
    end

    burst = 1'b0;
    drain();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pkrl_pkg.sv
sv/pkrl_if.sv
sv/pkrl_ram.sv
sv/pkrl_ctrl.sv
sv/per_key_fixed_window_rate_limiter_top.sv
dv/per_key_fixed_window_rate_limiter_top_tb.sv
